// ===== design/hpd_pkg.sv =====
// shared constants and types for the hexagonal prism distance unit
package hpd_pkg;

  localparam int unsigned KQ = 30;

  localparam logic [KQ-1:0] K_COS = 30'd929887693;
  localparam logic [KQ-1:0] K_TAN = 30'd619924842;
  localparam logic [KQ-1:0] K_RND = 30'd536870912;

  typedef enum logic {
    CFG_HEX_SIZE    = 1'b0,
    CFG_HALF_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

// ===== design/hpd_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage, rounded to nearest
module hpd_sqrt_pipe #(
  parameter int unsigned N  = 32,
  parameter int unsigned SW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [2*N-1:0] rad_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [N:0]     root_o,
  output logic [SW-1:0]  side_o
);

  localparam int unsigned RW = N + 2;

  logic           v_in   [N];
  logic [RW-1:0]  rem_in [N];
  logic [N-1:0]   r_in   [N];
  logic [2*N-1:0] rad_in [N];
  logic [SW-1:0]  sd_in  [N];

  logic [RW-1:0]  rem_sh [N];
  logic [RW-1:0]  trial  [N];
  logic           ge     [N];

  logic           v_q    [N];
  logic [RW-1:0]  rem_q  [N];
  logic [N-1:0]   r_q    [N];
  logic [2*N-1:0] rad_q  [N];
  logic [SW-1:0]  sd_q   [N];

  logic           out_v_q;
  logic [N:0]     root_q;
  logic [SW-1:0]  side_q;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      if (j == 0) begin
        v_in[j]   = valid_i;
        rem_in[j] = '0;
        r_in[j]   = '0;
        rad_in[j] = rad_i;
        sd_in[j]  = side_i;
      end else begin
        v_in[j]   = v_q[j-1];
        rem_in[j] = rem_q[j-1];
        r_in[j]   = r_q[j-1];
        rad_in[j] = rad_q[j-1];
        sd_in[j]  = sd_q[j-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      rem_sh[j] = {rem_in[j][RW-3:0], rad_in[j][2*N-1:2*N-2]};
      trial[j]  = {r_in[j], 2'b01};
      ge[j]     = rem_sh[j] >= trial[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < N; j++) begin
        v_q[j] <= 1'b0;
      end
      out_v_q <= 1'b0;
    end else if (en_i) begin
      for (int j = 0; j < N; j++) begin
        v_q[j] <= v_in[j];
      end
      out_v_q <= v_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N; j++) begin
        rem_q[j] <= ge[j] ? rem_sh[j] - trial[j] : rem_sh[j];
        r_q[j]   <= {r_in[j][N-2:0], ge[j]};
        rad_q[j] <= rad_in[j] << 2;
        sd_q[j]  <= sd_in[j];
      end
      root_q <= {1'b0, r_q[N-1]}
              + ((rem_q[N-1] > RW'(r_q[N-1])) ? (N+1)'(1) : (N+1)'(0));
      side_q <= sd_q[N-1];
    end
  end

  assign valid_o = out_v_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ===== design/hex_prism_distance_unit.sv =====
// hexagonal prism SDF, fully pipelined, one point per cycle unless stalled
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   pos_x, pos_y, pos_z
//  m_axis    out  m_axis_tvalid/m_axis_tready   distance
//  cfg       in   cfg_we_i                      hex_size, half_height
//
// one point per cycle sustained while the output is not stalled; the depth
// is mostly in the square root pipelines (WORD_BITS and WORD_BITS+1 stages)
// reset clears all valid bits; hex_size and half_height return to 1.0
// a stalled output freezes the whole pipeline; an input skid register keeps
// s_axis_tready registered, so a stall costs no transfer
module hex_prism_distance_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  hpd_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [WORD_BITS-2:0]          cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, pos_z
  input  logic [((3*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // distance
  output logic [((WORD_BITS+7)/8)*8-1:0] m_axis_tdata
);

  import hpd_pkg::*;

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned OTW  = ((W + 7) / 8) * 8;
  localparam int unsigned A1   = W - 1;
  localparam int unsigned L1   = (A1 + 1) / 2;
  localparam int unsigned H1   = A1 - L1;
  localparam int unsigned A2   = W;
  localparam int unsigned L2   = (A2 + 1) / 2;
  localparam int unsigned H2   = A2 - L2;
  localparam int unsigned SW1  = W + 4;
  localparam logic [W-2:0] ONE = (W-1)'(64'd1 << FRAC_BITS);
  localparam logic [W-2:0] LIM_RST =
    (W-1)'(((64'd1 << FRAC_BITS) * 64'd619924842 + 64'd536870912) >> KQ);
  localparam logic [W-1:0] CAP = W'(1) << (W - 1);

  // configuration
  logic [W-2:0] hs_q, hh_q, lim_q;
  logic [W+KQ-2:0] lim_p;

  assign lim_p = (W+KQ-1)'(hs_q) * (W+KQ-1)'(K_TAN) + (W+KQ-1)'(K_RND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q  <= ONE;
      hh_q  <= ONE;
      lim_q <= LIM_RST;
    end else begin
      lim_q <= lim_p[W+KQ-2:KQ];
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEX_SIZE:    hs_q <= cfg_data_i;
          CFG_HALF_HEIGHT: hh_q <= cfg_data_i;
          default:         ;
        endcase
      end
    end
  end

  // pipeline enable and input skid
  logic en;
  logic skid_q;
  logic [3*W-1:0] skid_data_q;
  logic src_v;
  logic [3*W-1:0] src;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_q;
  assign src_v         = skid_q || s_axis_tvalid;
  assign src           = skid_q ? skid_data_q : s_axis_tdata[3*W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (en) begin
      skid_q <= 1'b0;
    end else if (s_axis_tvalid && !skid_q) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && s_axis_tvalid && !skid_q) begin
      skid_data_q <= s_axis_tdata[3*W-1:0];
    end
  end

  // stage 1: magnitudes
  logic [W-1:0] px_in, py_in, pz_in;
  logic v1_q;
  logic [W-1:0] ax1_q, ay1_q, az1_q;

  assign px_in = src[W-1:0];
  assign py_in = src[2*W-1:W];
  assign pz_in = src[3*W-1:2*W];

  // stage 2: scaled magnitudes
  logic [W+KQ-1:0] c_p;
  logic [W:0] h_s;
  logic v2_q;
  logic [W-1:0] c2_q, h2_q, ax2_q, ay2_q, az2_q;

  assign c_p = (W+KQ)'(ax1_q) * (W+KQ)'(K_COS) + (W+KQ)'(K_RND);
  assign h_s = (W+1)'(ay1_q) + (W+1)'(1);

  // stage 3: fold offset
  logic v3_q;
  logic [W-1:0] d3_q, ax3_q, ay3_q, az3_q;

  // stage 4: fold products
  logic [W+KQ-1:0] t_p;
  logic v4_q;
  logic [W-1:0] t4_q, ax4_q, az4_q;
  logic [W:0] yr4_q;

  assign t_p = (W+KQ)'({d3_q[W-2:0], 1'b0}) * (W+KQ)'(K_COS) + (W+KQ)'(K_RND);

  // stage 5: folded point
  logic v5_q;
  logic signed [W:0] xr5_q;
  logic signed [W+1:0] ey5_q;
  logic [W-1:0] az5_q;

  // stage 6: edge offsets
  logic signed [W+1:0] xa, xb;
  logic v6_q;
  logic [W:0] mx6_q, my6_q;
  logic pos6_q, neg6_q, big6_q;
  logic signed [W:0] dz6_q;

  assign xa = $signed({xr5_q[W], xr5_q}) - $signed((W+2)'(lim_q));
  assign xb = -$signed({xr5_q[W], xr5_q}) - $signed((W+2)'(lim_q));

  // stage 7: partial products
  logic v7_q;
  logic [2*H1-1:0] xhh7_q, yhh7_q;
  logic [H1+L1-1:0] xhl7_q, yhl7_q;
  logic [2*L1-1:0] xll7_q, yll7_q;
  logic pos7_q, neg7_q, big7_q;
  logic signed [W:0] dz7_q;

  // stage 8: squares
  logic v8_q;
  logic [2*A1-1:0] sqx8_q, sqy8_q;
  logic pos8_q, neg8_q, big8_q;
  logic signed [W:0] dz8_q;

  // stage 9: sum of squares
  logic v9_q;
  logic [2*W-1:0] sum9_q;
  logic [SW1-1:0] side9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v1_q <= src_v;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= px_in[W-1] ? W'(0) - px_in : px_in;
      ay1_q <= py_in[W-1] ? W'(0) - py_in : py_in;
      az1_q <= pz_in[W-1] ? W'(0) - pz_in : pz_in;

      c2_q  <= c_p[W+KQ-1:KQ];
      h2_q  <= h_s[W:1];
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      az2_q <= az1_q;

      d3_q  <= (c2_q > h2_q) ? c2_q - h2_q : W'(0);
      ax3_q <= ax2_q;
      ay3_q <= ay2_q;
      az3_q <= az2_q;

      t4_q  <= t_p[W+KQ-1:KQ];
      yr4_q <= (W+1)'(ay3_q) + (W+1)'(d3_q);
      ax4_q <= ax3_q;
      az4_q <= az3_q;

      xr5_q <= $signed((W+1)'(ax4_q)) - $signed((W+1)'(t4_q));
      ey5_q <= $signed((W+2)'(yr4_q)) - $signed((W+2)'(hs_q));
      az5_q <= az4_q;

      if (!xa[W+1] && xa != '0) begin
        mx6_q <= xa[W:0];
      end else if (!xb[W+1] && xb != '0) begin
        mx6_q <= xb[W:0];
      end else begin
        mx6_q <= '0;
      end
      my6_q  <= ey5_q[W+1] ? (W+1)'(-ey5_q) : ey5_q[W:0];
      pos6_q <= !ey5_q[W+1] && ey5_q != '0;
      neg6_q <= ey5_q[W+1];
      dz6_q  <= $signed((W+1)'(az5_q)) - $signed((W+1)'(hh_q));

      xhh7_q <= (2*H1)'(mx6_q[A1-1:L1]) * (2*H1)'(mx6_q[A1-1:L1]);
      xhl7_q <= (H1+L1)'(mx6_q[A1-1:L1]) * (H1+L1)'(mx6_q[L1-1:0]);
      xll7_q <= (2*L1)'(mx6_q[L1-1:0]) * (2*L1)'(mx6_q[L1-1:0]);
      yhh7_q <= (2*H1)'(my6_q[A1-1:L1]) * (2*H1)'(my6_q[A1-1:L1]);
      yhl7_q <= (H1+L1)'(my6_q[A1-1:L1]) * (H1+L1)'(my6_q[L1-1:0]);
      yll7_q <= (2*L1)'(my6_q[L1-1:0]) * (2*L1)'(my6_q[L1-1:0]);
      pos7_q <= pos6_q;
      neg7_q <= neg6_q;
      big7_q <= mx6_q[W:W-1] != 2'b00 || my6_q[W:W-1] != 2'b00;
      dz7_q  <= dz6_q;

      sqx8_q <= ((2*A1)'(xhh7_q) << (2*L1)) + ((2*A1)'(xhl7_q) << (L1+1))
              + (2*A1)'(xll7_q);
      sqy8_q <= ((2*A1)'(yhh7_q) << (2*L1)) + ((2*A1)'(yhl7_q) << (L1+1))
              + (2*A1)'(yll7_q);
      pos8_q <= pos7_q;
      neg8_q <= neg7_q;
      big8_q <= big7_q;
      dz8_q  <= dz7_q;

      sum9_q  <= (2*W)'(sqx8_q) + (2*W)'(sqy8_q);
      side9_q <= {big8_q, pos8_q, neg8_q, dz8_q};
    end
  end

  // edge length
  logic vr1;
  logic [W:0] root1;
  logic [SW1-1:0] side1;

  hpd_sqrt_pipe #(
    .N  (W),
    .SW (SW1)
  ) u_sqrt_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .rad_i   (sum9_q),
    .side_i  (side9_q),
    .valid_o (vr1),
    .root_o  (root1),
    .side_o  (side1)
  );

  // stage a: signed edge distance
  logic [W-1:0] len;
  logic vA_q;
  logic signed [W:0] dsA_q, dzA_q;

  assign len = side1[W+3] ? CAP : root1[W-1:0];

  // stage b: inner and outer parts
  logic signed [W:0] dmax;
  logic vB_q;
  logic signed [W:0] innerB_q;
  logic [W-1:0] pxB_q, pzB_q;

  assign dmax = (dsA_q > dzA_q) ? dsA_q : dzA_q;

  // stage c: partial products
  logic vC_q;
  logic [2*H2-1:0] phh_q, zhh_q;
  logic [H2+L2-1:0] phl_q, zhl_q;
  logic [2*L2-1:0] pll_q, zll_q;
  logic signed [W:0] innerC_q;

  // stage d: squares
  logic vD_q;
  logic [2*A2-1:0] sqp_q, sqz_q;
  logic signed [W:0] innerD_q;

  // stage e: sum of squares
  logic vE_q;
  logic [2*W+1:0] sumE_q;
  logic [W:0] innerE_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
      vC_q <= 1'b0;
      vD_q <= 1'b0;
      vE_q <= 1'b0;
    end else if (en) begin
      vA_q <= vr1;
      vB_q <= vA_q;
      vC_q <= vB_q;
      vD_q <= vC_q;
      vE_q <= vD_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side1[W+2]) begin
        dsA_q <= $signed((W+1)'(len));
      end else if (side1[W+1]) begin
        dsA_q <= -$signed((W+1)'(len));
      end else begin
        dsA_q <= '0;
      end
      dzA_q <= $signed(side1[W:0]);

      innerB_q <= dmax[W] ? dmax : '0;
      pxB_q    <= dsA_q[W] ? W'(0) : dsA_q[W-1:0];
      pzB_q    <= dzA_q[W] ? W'(0) : dzA_q[W-1:0];

      phh_q    <= (2*H2)'(pxB_q[A2-1:L2]) * (2*H2)'(pxB_q[A2-1:L2]);
      phl_q    <= (H2+L2)'(pxB_q[A2-1:L2]) * (H2+L2)'(pxB_q[L2-1:0]);
      pll_q    <= (2*L2)'(pxB_q[L2-1:0]) * (2*L2)'(pxB_q[L2-1:0]);
      zhh_q    <= (2*H2)'(pzB_q[A2-1:L2]) * (2*H2)'(pzB_q[A2-1:L2]);
      zhl_q    <= (H2+L2)'(pzB_q[A2-1:L2]) * (H2+L2)'(pzB_q[L2-1:0]);
      zll_q    <= (2*L2)'(pzB_q[L2-1:0]) * (2*L2)'(pzB_q[L2-1:0]);
      innerC_q <= innerB_q;

      sqp_q    <= ((2*A2)'(phh_q) << (2*L2)) + ((2*A2)'(phl_q) << (L2+1))
                + (2*A2)'(pll_q);
      sqz_q    <= ((2*A2)'(zhh_q) << (2*L2)) + ((2*A2)'(zhl_q) << (L2+1))
                + (2*A2)'(zll_q);
      innerD_q <= innerC_q;

      sumE_q   <= (2*W+2)'(sqp_q) + (2*W+2)'(sqz_q);
      innerE_q <= innerD_q;
    end
  end

  // outer length
  logic vr2;
  logic [W+1:0] root2;
  logic [W:0] inner2;

  hpd_sqrt_pipe #(
    .N  (W + 1),
    .SW (W + 1)
  ) u_sqrt_outer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vE_q),
    .rad_i   (sumE_q),
    .side_i  (innerE_q),
    .valid_o (vr2),
    .root_o  (root2),
    .side_o  (inner2)
  );

  // stage f: combine, stage g: saturate into the output register
  logic vF_q;
  logic signed [W+2:0] resF_q;
  logic [W-1:0] dist_q;
  logic [3:0] top;

  assign top = resF_q[W+2:W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vF_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vF_q          <= vr2;
      m_axis_tvalid <= vF_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      resF_q <= $signed({{2{inner2[W]}}, inner2}) + $signed({1'b0, root2});
      if (top == 4'b0000 || top == 4'b1111) begin
        dist_q <= resF_q[W-1:0];
      end else if (resF_q[W+2]) begin
        dist_q <= CAP;
      end else begin
        dist_q <= ~CAP;
      end
    end
  end

  assign m_axis_tdata = OTW'(dist_q);

endmodule

// ===== tb/hex_prism_distance_unit_chk.sv =====
// checker for the hexagonal prism distance unit: predicts and compares transfers
`timescale 1ns / 1ps
module hex_prism_distance_unit_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  hpd_pkg::cfg_idx_e cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);
  import hpd_pkg::*;

  localparam logic [63:0] CAP = 64'd1 << 31;

  logic [63:0] hex_size_q, half_height_q;
  logic [31:0] dist_q[$];

  function automatic logic [63:0] scale_k(logic [63:0] m, logic [63:0] k);
    logic [63:0] mh, ml;
    mh = m >> KQ;
    ml = m & ((64'd1 << KQ) - 1);
    return mh * k + ((ml * k + (64'd1 << (KQ - 1))) >> KQ);
  endfunction

  function automatic logic [63:0] hypot_rnd(logic [63:0] p, logic [63:0] q);
    logic [127:0] s, rem, r, trial;
    s = {64'd0, p} * {64'd0, p} + {64'd0, q} * {64'd0, q};
    rem = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((s >> (2 * i)) & 128'd3);
      trial = (r << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 128'd1;
      end else begin
        r = r << 1;
      end
    end
    return (rem > r) ? r[63:0] + 64'd1 : r[63:0];
  endfunction

  function automatic logic [63:0] mag32(logic [31:0] v);
    return v[31] ? {32'd0, ~v} + 64'd1 : {32'd0, v};
  endfunction

  function automatic logic [31:0] prism_distance(logic [95:0] d);
    logic [63:0] ax, ay, az, c, h, u, mx, my, len;
    longint xr, yr, lim, cl, ex, ey, ds, dz, inner, px, pz, res;
    ax = mag32(d[31:0]);
    ay = mag32(d[63:32]);
    az = mag32(d[95:64]);
    c = scale_k(ax, K_COS);
    h = scale_k(ay, K_RND);
    u = (c > h) ? 64'd2 * (c - h) : 64'd0;
    xr = longint'(ax) - longint'(scale_k(u, K_COS));
    yr = longint'(ay + u / 2);
    lim = longint'(scale_k(hex_size_q, K_TAN));
    cl = (xr < -lim) ? -lim : ((xr > lim) ? lim : xr);
    ex = xr - cl;
    ey = yr - longint'(hex_size_q);
    mx = (ex < 0) ? -ex : ex;
    my = (ey < 0) ? -ey : ey;
    len = (mx >= CAP || my >= CAP) ? CAP : hypot_rnd(mx, my);
    ds = (ey > 0) ? longint'(len) : ((ey < 0) ? -longint'(len) : 0);
    dz = longint'(az) - longint'(half_height_q);
    inner = (ds > dz) ? ds : dz;
    if (inner > 0) inner = 0;
    px = (ds > 0) ? ds : 0;
    pz = (dz > 0) ? dz : 0;
    res = inner + longint'(hypot_rnd(px, pz));
    if (res < -longint'(CAP)) res = -longint'(CAP);
    if (res > longint'(CAP) - 1) res = longint'(CAP) - 1;
    return res[31:0];
  endfunction

  assign pending_o = dist_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_size_q <= 64'd1 << 16;
      half_height_q <= 64'd1 << 16;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEX_SIZE) hex_size_q <= {33'd0, cfg_data_i};
        else half_height_q <= {33'd0, cfg_data_i};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (dist_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual %h", $time, m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          if (dist_q[0] !== m_axis_tdata) begin
            $display("%0t distance mismatch: expected %h, actual %h",
                     $time, dist_q[0], m_axis_tdata);
            errors_o <= errors_o + 1;
          end
          void'(dist_q.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) dist_q.push_back(prism_distance(s_axis_tdata));
    end
  end
endmodule

// ===== tb/hex_prism_distance_unit_tb.sv =====
// testbench top for the hexagonal prism distance unit: stimulus and verdict
`timescale 1ns / 1ps
module hex_prism_distance_unit_tb;
  import hpd_pkg::*;

  localparam int LATENCY = 2 * 32 + 19;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_HEX_SIZE;
  logic [30:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int errors, pending, cycles = 0;
  bit calm = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hex_prism_distance_unit dut (.*);
  hex_prism_distance_unit_chk u_chk (.*, .errors_o(errors), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("hex_prism_distance_unit_tb: errors");
      $finish;
    end
  end

  int ready_hold = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= ~m_axis_tready;
      ready_hold <= $urandom_range(1, 12) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      3: return 32'(int'($urandom_range(0, 6 << 16)) - (3 << 16));
      default: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  logic [30:0] sizes[5] = '{31'h7fff_ffff, 31'd0, 31'd1 << 16, 31'd3 << 15, 31'd5 << 16};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0, 32'h0001_0000, 32'h0);
    send_point(32'h0, 32'hffff_0000, 32'h0001_0000);
    send_point(32'h0002_0000, 32'h0, 32'h0);
    send_point(32'hfffe_0000, 32'h0000_8000, 32'h0003_0000);
    send_point(32'h0000_93cd, 32'h0001_0000, 32'h0);
    send_point(32'h0, 32'h0, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h0, 32'h0);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_point(32'h0000_ddb3, 32'h0000_8000, 32'h0000_8000);
    for (int p = 0; p < 8; p++) begin
      drain();
      write_reg(CFG_HEX_SIZE, (p < 5) ? sizes[p] : 31'($urandom_range(0, 4 << 16)));
      write_reg(CFG_HALF_HEIGHT, (p < 5) ? sizes[4 - p] : 31'($urandom));
      if (p == 7) calm = 1;
      for (int i = 0; i < 100; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    end
    drain();
    if (errors == 0) begin
      $display("hex_prism_distance_unit_tb: clean");
    end else begin
      $display("hex_prism_distance_unit_tb: errors");
    end
    $finish;
  end
endmodule
